[rtl/core/cmca_pkg.sv]
// Package with the shared sizes, codes, record types and term helpers of the arena.
`timescale 1ns / 1ps
package cmca_pkg;

  localparam int NODE_DEPTH = 4096;
  localparam int DEF_DEPTH  = 256;
  localparam int CHILDREN   = 4;
  localparam int TERM_W     = 12;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int NCNT_W     = NODE_AW + 1;
  localparam int DEF_AW     = $clog2(DEF_DEPTH);
  localparam int DCNT_W     = DEF_AW + 1;

  typedef enum logic [3:0] {
    OP_APPEND_NODE = 4'd0,
    OP_APPEND_DEF  = 4'd1,
    OP_CHECKPOINT  = 4'd2,
    OP_ROLLBACK    = 4'd3,
    OP_COMMIT      = 4'd4,
    OP_READ_NODE   = 4'd5,
    OP_READ_DEF    = 4'd6,
    OP_RELOCATE    = 4'd7,
    OP_RAISE_ERROR = 4'd8
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_ERROR   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // One arena entry: children in order a..d, then the reference flag.
  typedef struct packed {
    logic [CHILDREN-1:0][TERM_W-1:0] ch;
    logic                            rf;
  } node_t;

  typedef struct packed {
    logic [TERM_W-1:0] value;
    logic [TERM_W-1:0] dtype;
  } def_t;

  // True when a term lies in the region [base, count).
  function automatic logic in_region(logic [TERM_W-1:0] t, logic [NCNT_W-1:0] base,
                                     logic [NCNT_W-1:0] count);
    logic [NCNT_W-1:0] te;
    te = NCNT_W'(t);
    return (te >= base) && (te < count);
  endfunction

  // Translates a term through the map entry that was read for it.
  function automatic logic [TERM_W-1:0] rewrite(logic [TERM_W-1:0] t,
                                                logic [NCNT_W-1:0] base,
                                                logic [NCNT_W-1:0] count,
                                                logic [NCNT_W-1:0] mv);
    logic [NCNT_W-1:0] te;
    te = NCNT_W'(t);
    if (te < base) return t;
    else if (te < count) return TERM_W'(mv);
    else return '0;
  endfunction

endpackage

[rtl/core/cmca_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module cmca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered and valid in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/checkpoint_mark_compact_arena.sv]
// Top level of the checkpointed arena with mark-compact commit.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid_i / in_ready_o | opcode_i, index_i, child_*_i, ...
//   out     | output    | out_valid_o / out_ready_i | status_o, out_*_o, counts
//
// Appends, checkpoint, rollback and raise error complete straight from idle; node
// and definition reads and relocate pass a wait state for the memory read. A commit
// clears the map, marks the new definitions' terms as roots, marks backward (up to
// four map writes per live node), compacts (four map lookups per live node) and
// rewrites the new definitions, all through the single map port. Reset sets the
// node count to one and clears the other counts, marks and flags at once; no memory
// is swept. A new transfer is taken only while no operation is in flight and the
// output register is empty or being emptied in the same cycle.
`timescale 1ns / 1ps
module checkpoint_mark_compact_arena (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  opcode_i,
  input  logic [cmca_pkg::TERM_W-1:0] index_i,
  input  logic [cmca_pkg::TERM_W-1:0] child_a_i,
  input  logic [cmca_pkg::TERM_W-1:0] child_b_i,
  input  logic [cmca_pkg::TERM_W-1:0] child_c_i,
  input  logic [cmca_pkg::TERM_W-1:0] child_d_i,
  input  logic                        is_defref_i,
  input  logic [cmca_pkg::TERM_W-1:0] def_value_i,
  input  logic [cmca_pkg::TERM_W-1:0] def_type_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [cmca_pkg::TERM_W-1:0] out_child_a_o,
  output logic [cmca_pkg::TERM_W-1:0] out_child_b_o,
  output logic [cmca_pkg::TERM_W-1:0] out_child_c_o,
  output logic [cmca_pkg::TERM_W-1:0] out_child_d_o,
  output logic                        out_is_defref_o,
  output logic [cmca_pkg::TERM_W-1:0] out_def_value_o,
  output logic [cmca_pkg::TERM_W-1:0] out_def_type_o,
  output logic [cmca_pkg::TERM_W-1:0] out_term_o,
  output logic [cmca_pkg::NCNT_W-1:0] node_count_o,
  output logic [cmca_pkg::DCNT_W-1:0] def_count_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_RDWAIT, S_CLR, S_DR0, S_DR1, S_DR2, S_BK0, S_BK1, S_BKW,
    S_CP0, S_CP1, S_CPM, S_CPW, S_DF0, S_DF1, S_DF2, S_DF3, S_FIN
  } state_e;

  state_e state_q;

  // Architectural registers.
  logic [cmca_pkg::NCNT_W-1:0] arena_q, mark_nodes_q, reloc_start_q, reloc_len_q;
  logic [cmca_pkg::DCNT_W-1:0] defs_q, mark_defs_q;
  logic                        reloc_valid_q, err_q;

  // Commit and read working registers.
  logic [3:0]                  op_q;
  logic [cmca_pkg::TERM_W-1:0] idx_q;
  logic [cmca_pkg::NCNT_W-1:0] iter_q, next_q;
  logic [cmca_pkg::DCNT_W-1:0] def_it_q;
  logic [2:0]                  j_q;
  logic [cmca_pkg::CHILDREN-1:0][cmca_pkg::TERM_W-1:0] ch_q, nch_q;
  logic                        rf_q;
  logic [cmca_pkg::TERM_W-1:0] dv_q, dt_q;

  // Output register.
  logic                        out_valid_q;
  logic [1:0]                  status_q;
  cmca_pkg::node_t             onode_q;
  cmca_pkg::def_t              odef_q;
  logic [cmca_pkg::TERM_W-1:0] oterm_q;
  logic [cmca_pkg::NCNT_W-1:0] ocnt_q;
  logic [cmca_pkg::DCNT_W-1:0] odcnt_q;

  // Memory ports.
  logic                         node_we, node_re, map_we, map_re, def_we, def_re;
  logic [cmca_pkg::NODE_AW-1:0] node_waddr, node_raddr, map_waddr, map_raddr;
  logic [cmca_pkg::DEF_AW-1:0]  def_waddr, def_raddr;
  cmca_pkg::node_t              node_wdata, node_rdata;
  cmca_pkg::def_t               def_wdata, def_rdata;
  logic [cmca_pkg::NCNT_W-1:0]  map_wdata, map_rdata;

  logic                         in_fire;
  logic [cmca_pkg::NCNT_W-1:0]  len_w, n_w, idx_e;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign len_w      = arena_q - mark_nodes_q;
  assign n_w        = iter_q - cmca_pkg::NCNT_W'(1);
  assign idx_e      = cmca_pkg::NCNT_W'(idx_q);

  cmca_ram #(.WIDTH($bits(cmca_pkg::node_t)), .DEPTH(cmca_pkg::NODE_DEPTH)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(node_rdata)
  );

  cmca_ram #(.WIDTH(cmca_pkg::NCNT_W), .DEPTH(cmca_pkg::NODE_DEPTH)) u_map_ram (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .re_i(map_re), .raddr_i(map_raddr), .rdata_o(map_rdata)
  );

  cmca_ram #(.WIDTH($bits(cmca_pkg::def_t)), .DEPTH(cmca_pkg::DEF_DEPTH)) u_def_ram (
    .clk_i, .we_i(def_we), .waddr_i(def_waddr), .wdata_i(def_wdata),
    .re_i(def_re), .raddr_i(def_raddr), .rdata_o(def_rdata)
  );

  // Memory address, data and enable selection for each state.
  always_comb begin
    node_we    = 1'b0;
    node_re    = 1'b0;
    map_we     = 1'b0;
    map_re     = 1'b0;
    def_we     = 1'b0;
    def_re     = 1'b0;
    node_waddr = arena_q[cmca_pkg::NODE_AW-1:0];
    node_raddr = index_i[cmca_pkg::NODE_AW-1:0];
    node_wdata = '{ch: {child_d_i, child_c_i, child_b_i, child_a_i}, rf: is_defref_i};
    map_waddr  = iter_q[cmca_pkg::NODE_AW-1:0];
    map_raddr  = cmca_pkg::NODE_AW'(cmca_pkg::NCNT_W'(index_i) - reloc_start_q);
    map_wdata  = '0;
    def_waddr  = defs_q[cmca_pkg::DEF_AW-1:0];
    def_raddr  = index_i[cmca_pkg::DEF_AW-1:0];
    def_wdata  = '{value: def_value_i, dtype: def_type_i};
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (opcode_i)
            cmca_pkg::OP_APPEND_NODE: node_we = (arena_q < cmca_pkg::NCNT_W'(cmca_pkg::NODE_DEPTH));
            cmca_pkg::OP_APPEND_DEF:  def_we  = (defs_q < cmca_pkg::DCNT_W'(cmca_pkg::DEF_DEPTH));
            cmca_pkg::OP_READ_NODE:   node_re = 1'b1;
            cmca_pkg::OP_READ_DEF:    def_re  = 1'b1;
            cmca_pkg::OP_RELOCATE:    map_re  = 1'b1;
            default: ;
          endcase
        end
      end
      S_CLR: begin
        map_we = (iter_q < len_w);
      end
      S_DR0: begin
        def_re    = 1'b1;
        def_raddr = def_it_q[cmca_pkg::DEF_AW-1:0];
      end
      S_DR1: begin
        map_we    = cmca_pkg::in_region(def_rdata.value, mark_nodes_q, arena_q);
        map_waddr = cmca_pkg::NODE_AW'(cmca_pkg::NCNT_W'(def_rdata.value) - mark_nodes_q);
        map_wdata = cmca_pkg::NCNT_W'(1);
      end
      S_DR2: begin
        map_we    = cmca_pkg::in_region(dt_q, mark_nodes_q, arena_q);
        map_waddr = cmca_pkg::NODE_AW'(cmca_pkg::NCNT_W'(dt_q) - mark_nodes_q);
        map_wdata = cmca_pkg::NCNT_W'(1);
      end
      S_BK0: begin
        node_re    = 1'b1;
        node_raddr = n_w[cmca_pkg::NODE_AW-1:0];
        map_re     = 1'b1;
        map_raddr  = cmca_pkg::NODE_AW'(n_w - mark_nodes_q);
      end
      S_BK1: begin
        map_we    = node_rdata.rf;
        map_waddr = cmca_pkg::NODE_AW'(n_w - mark_nodes_q);
        map_wdata = cmca_pkg::NCNT_W'(1);
      end
      S_BKW: begin
        map_we    = cmca_pkg::in_region(ch_q[j_q[1:0]], mark_nodes_q, arena_q);
        map_waddr = cmca_pkg::NODE_AW'(cmca_pkg::NCNT_W'(ch_q[j_q[1:0]]) - mark_nodes_q);
        map_wdata = cmca_pkg::NCNT_W'(1);
      end
      S_CP0: begin
        node_re    = 1'b1;
        node_raddr = iter_q[cmca_pkg::NODE_AW-1:0];
        map_re     = 1'b1;
        map_raddr  = cmca_pkg::NODE_AW'(iter_q - mark_nodes_q);
      end
      S_CPM: begin
        map_re    = (j_q != 3'd4);
        map_raddr = cmca_pkg::NODE_AW'(cmca_pkg::NCNT_W'(ch_q[j_q[1:0]]) - mark_nodes_q);
      end
      S_CPW: begin
        map_we     = 1'b1;
        map_waddr  = cmca_pkg::NODE_AW'(iter_q - mark_nodes_q);
        map_wdata  = next_q;
        node_we    = 1'b1;
        node_waddr = next_q[cmca_pkg::NODE_AW-1:0];
        node_wdata = '{ch: nch_q, rf: rf_q};
      end
      S_DF0: begin
        def_re    = 1'b1;
        def_raddr = def_it_q[cmca_pkg::DEF_AW-1:0];
      end
      S_DF1: begin
        map_re    = 1'b1;
        map_raddr = cmca_pkg::NODE_AW'(cmca_pkg::NCNT_W'(def_rdata.value) - mark_nodes_q);
      end
      S_DF2: begin
        map_re    = 1'b1;
        map_raddr = cmca_pkg::NODE_AW'(cmca_pkg::NCNT_W'(dt_q) - mark_nodes_q);
      end
      S_DF3: begin
        def_we    = 1'b1;
        def_waddr = def_it_q[cmca_pkg::DEF_AW-1:0];
        def_wdata = '{value: dv_q,
                      dtype: cmca_pkg::rewrite(dt_q, mark_nodes_q, arena_q, map_rdata)};
      end
      default: ;
    endcase
  end

  // Sequencer, architectural state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      arena_q       <= cmca_pkg::NCNT_W'(1);
      defs_q        <= '0;
      mark_nodes_q  <= '0;
      mark_defs_q   <= '0;
      reloc_start_q <= '0;
      reloc_len_q   <= '0;
      reloc_valid_q <= 1'b0;
      err_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      iter_q        <= '0;
      next_q        <= '0;
      def_it_q      <= '0;
      j_q           <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q     <= opcode_i;
            idx_q    <= index_i;
            status_q <= cmca_pkg::ST_DONE;
            onode_q  <= '0;
            odef_q   <= '0;
            oterm_q  <= '0;
            ocnt_q   <= arena_q;
            odcnt_q  <= defs_q;
            out_valid_q <= 1'b1;
            unique case (opcode_i)
              cmca_pkg::OP_APPEND_NODE: begin
                if (arena_q < cmca_pkg::NCNT_W'(cmca_pkg::NODE_DEPTH)) begin
                  arena_q <= arena_q + cmca_pkg::NCNT_W'(1);
                  ocnt_q  <= arena_q + cmca_pkg::NCNT_W'(1);
                  oterm_q <= cmca_pkg::TERM_W'(arena_q);
                end else begin
                  status_q <= cmca_pkg::ST_FULL;
                end
              end
              cmca_pkg::OP_APPEND_DEF: begin
                if (defs_q < cmca_pkg::DCNT_W'(cmca_pkg::DEF_DEPTH)) begin
                  defs_q  <= defs_q + cmca_pkg::DCNT_W'(1);
                  odcnt_q <= defs_q + cmca_pkg::DCNT_W'(1);
                end else begin
                  status_q <= cmca_pkg::ST_FULL;
                end
              end
              cmca_pkg::OP_CHECKPOINT: begin
                reloc_valid_q <= 1'b0;
                reloc_len_q   <= '0;
                mark_nodes_q  <= arena_q;
                mark_defs_q   <= defs_q;
              end
              cmca_pkg::OP_ROLLBACK: begin
                if (mark_nodes_q == '0) begin
                  status_q <= cmca_pkg::ST_IGNORED;
                end else begin
                  arena_q      <= mark_nodes_q;
                  defs_q       <= mark_defs_q;
                  ocnt_q       <= mark_nodes_q;
                  odcnt_q      <= mark_defs_q;
                  mark_nodes_q <= '0;
                  err_q        <= 1'b0;
                end
              end
              cmca_pkg::OP_COMMIT: begin
                if (mark_nodes_q == '0) begin
                  status_q <= cmca_pkg::ST_IGNORED;
                end else if (err_q) begin
                  status_q <= cmca_pkg::ST_ERROR;
                end else begin
                  out_valid_q <= 1'b0;
                  iter_q      <= '0;
                  state_q     <= S_CLR;
                end
              end
              cmca_pkg::OP_READ_NODE, cmca_pkg::OP_READ_DEF, cmca_pkg::OP_RELOCATE: begin
                out_valid_q <= 1'b0;
                state_q     <= S_RDWAIT;
              end
              cmca_pkg::OP_RAISE_ERROR: begin
                err_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end

        // Finish a read once the memory data is in.
        S_RDWAIT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
          unique case (op_q)
            cmca_pkg::OP_READ_NODE: onode_q <= node_rdata;
            cmca_pkg::OP_READ_DEF: begin
              if (idx_e < cmca_pkg::NCNT_W'(cmca_pkg::DEF_DEPTH)) begin
                odef_q <= def_rdata;
              end
            end
            default: begin
              if (idx_q == '0) begin
                oterm_q <= '0;
              end else if (!reloc_valid_q || (idx_e < reloc_start_q)) begin
                oterm_q <= idx_q;
              end else if ((idx_e - reloc_start_q) < reloc_len_q) begin
                oterm_q <= cmca_pkg::TERM_W'(map_rdata);
              end else begin
                oterm_q <= '0;
              end
            end
          endcase
        end

        // Clear the map over the region.
        S_CLR: begin
          if (iter_q < len_w) begin
            iter_q <= iter_q + cmca_pkg::NCNT_W'(1);
          end else begin
            def_it_q <= mark_defs_q;
            state_q  <= S_DR0;
          end
        end

        // Mark the terms of new definitions as roots.
        S_DR0: begin
          if (def_it_q < defs_q) begin
            state_q <= S_DR1;
          end else begin
            iter_q  <= arena_q;
            state_q <= S_BK0;
          end
        end
        S_DR1: begin
          dt_q    <= def_rdata.dtype;
          state_q <= S_DR2;
        end
        S_DR2: begin
          def_it_q <= def_it_q + cmca_pkg::DCNT_W'(1);
          state_q  <= S_DR0;
        end

        // Backward marking pass; reference nodes count as marked.
        S_BK0: begin
          if (iter_q > mark_nodes_q) begin
            state_q <= S_BK1;
          end else begin
            iter_q  <= mark_nodes_q;
            next_q  <= mark_nodes_q;
            state_q <= S_CP0;
          end
        end
        S_BK1: begin
          ch_q <= node_rdata.ch;
          j_q  <= '0;
          if ((map_rdata != '0) || node_rdata.rf) begin
            state_q <= S_BKW;
          end else begin
            iter_q  <= n_w;
            state_q <= S_BK0;
          end
        end
        S_BKW: begin
          if (j_q == 3'(cmca_pkg::CHILDREN - 1)) begin
            iter_q  <= n_w;
            state_q <= S_BK0;
          end else begin
            j_q <= j_q + 3'd1;
          end
        end

        // Compaction pass: look up each child, then move the node down.
        S_CP0: begin
          if (iter_q < arena_q) begin
            state_q <= S_CP1;
          end else begin
            def_it_q <= mark_defs_q;
            state_q  <= S_DF0;
          end
        end
        S_CP1: begin
          ch_q <= node_rdata.ch;
          rf_q <= node_rdata.rf;
          j_q  <= '0;
          if (map_rdata != '0) begin
            state_q <= S_CPM;
          end else begin
            iter_q  <= iter_q + cmca_pkg::NCNT_W'(1);
            state_q <= S_CP0;
          end
        end
        S_CPM: begin
          if (j_q != 3'd0) begin
            nch_q[j_q[1:0] - 2'd1] <= cmca_pkg::rewrite(ch_q[j_q[1:0] - 2'd1], mark_nodes_q,
                                                        arena_q, map_rdata);
          end
          if (j_q == 3'(cmca_pkg::CHILDREN)) begin
            state_q <= S_CPW;
          end else begin
            j_q <= j_q + 3'd1;
          end
        end
        S_CPW: begin
          next_q  <= next_q + cmca_pkg::NCNT_W'(1);
          iter_q  <= iter_q + cmca_pkg::NCNT_W'(1);
          state_q <= S_CP0;
        end

        // Rewrite the new definitions.
        S_DF0: begin
          if (def_it_q < defs_q) begin
            state_q <= S_DF1;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DF1: begin
          dv_q    <= def_rdata.value;
          dt_q    <= def_rdata.dtype;
          state_q <= S_DF2;
        end
        S_DF2: begin
          dv_q    <= cmca_pkg::rewrite(dv_q, mark_nodes_q, arena_q, map_rdata);
          state_q <= S_DF3;
        end
        S_DF3: begin
          def_it_q <= def_it_q + cmca_pkg::DCNT_W'(1);
          state_q  <= S_DF0;
        end

        // Publish the new counts and keep the map for relocation.
        S_FIN: begin
          arena_q       <= next_q;
          mark_nodes_q  <= '0;
          reloc_valid_q <= 1'b1;
          reloc_start_q <= mark_nodes_q;
          reloc_len_q   <= len_w;
          ocnt_q        <= next_q;
          odcnt_q       <= defs_q;
          out_valid_q   <= 1'b1;
          state_q       <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign out_child_a_o   = onode_q.ch[0];
  assign out_child_b_o   = onode_q.ch[1];
  assign out_child_c_o   = onode_q.ch[2];
  assign out_child_d_o   = onode_q.ch[3];
  assign out_is_defref_o = onode_q.rf;
  assign out_def_value_o = odef_q.value;
  assign out_def_type_o  = odef_q.dtype;
  assign out_term_o      = oterm_q;
  assign node_count_o    = ocnt_q;
  assign def_count_o     = odcnt_q;

endmodule

[rtl/core/cmca_checker.sv]
// Port-level checker for the arena, bound to the top level.
`timescale 1ns / 1ps
module cmca_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic [cmca_pkg::NCNT_W-1:0] node_count_o,
  input logic [cmca_pkg::DCNT_W-1:0] def_count_o
);

  // A stalled result holds its status and node count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(node_count_o))
    else $error("stalled result changed");

  // New work is never taken while a result is stuck.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(out_valid_o && !out_ready_i))
    else $error("input taken over a stalled result");

  // The null term always stays in the arena.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (node_count_o != '0))
    else $error("arena count dropped to zero");

  // Counts never pass the store depths.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (node_count_o <= cmca_pkg::NCNT_W'(cmca_pkg::NODE_DEPTH)) &&
                    (def_count_o <= cmca_pkg::DCNT_W'(cmca_pkg::DEF_DEPTH)))
    else $error("count beyond store depth");

endmodule

bind checkpoint_mark_compact_arena cmca_checker u_cmca_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .status_o,
  .node_count_o, .def_count_o
);

[bench/tb_checkpoint_mark_compact_arena.sv]
// Self-checking testbench for the checkpointed mark-compact node arena.
`timescale 1ns / 1ps
module tb_checkpoint_mark_compact_arena;

  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int         TAIL_CYCLES = 200;

  typedef struct {
    logic [3:0]                  op;
    logic [cmca_pkg::TERM_W-1:0] index;
    logic [cmca_pkg::TERM_W-1:0] ch [cmca_pkg::CHILDREN];
    logic                        defref;
    logic [cmca_pkg::TERM_W-1:0] dvalue;
    logic [cmca_pkg::TERM_W-1:0] dtype;
  } arena_req_t;

  typedef struct {
    logic [1:0]                  status;
    logic [cmca_pkg::TERM_W-1:0] ch [cmca_pkg::CHILDREN];
    logic                        defref;
    logic [cmca_pkg::TERM_W-1:0] dvalue;
    logic [cmca_pkg::TERM_W-1:0] dtype;
    logic [cmca_pkg::TERM_W-1:0] term;
    logic [cmca_pkg::NCNT_W-1:0] ncount;
    logic [cmca_pkg::DCNT_W-1:0] dcount;
  } arena_rsp_t;

  // Scoreboard: keeps a shadow copy of the arena and the queue of expected responses.
  class arena_scoreboard;
    logic [cmca_pkg::TERM_W-1:0] node_ch [cmca_pkg::NODE_DEPTH][cmca_pkg::CHILDREN];
    bit                          node_rf [cmca_pkg::NODE_DEPTH];
    logic [cmca_pkg::TERM_W-1:0] defs [cmca_pkg::DEF_DEPTH][2];
    int unsigned                 map_tab [cmca_pkg::NODE_DEPTH];
    int unsigned                 nodes, defs_n, cp_nodes, cp_defs, rel_start, rel_len;
    bit                          rel_ok, err_flag;
    int unsigned                 node_hi, def_hi;
    arena_rsp_t                  pending [$];
    int                          errors;

    function new();
      nodes = 1; defs_n = 0; cp_nodes = 0; cp_defs = 0;
      rel_start = 0; rel_len = 0; rel_ok = 0; err_flag = 0;
      node_hi = 1; def_hi = 0; errors = 0;
    endfunction

    function bit in_span(int unsigned t, int unsigned base, int unsigned count);
      return t >= base && t < count;
    endfunction

    function int unsigned remap(int unsigned t, int unsigned base, int unsigned count);
      if (t < base) return t;
      if (t < count) return map_tab[t - base];
      return 0;
    endfunction

    // Mark from the roots, then slide live nodes down and rewrite the new definitions.
    function void compact();
      int unsigned base, count, nxt, n;
      logic [cmca_pkg::TERM_W-1:0] tmp [cmca_pkg::CHILDREN];
      bit rfv;
      base = cp_nodes;
      count = nodes;
      foreach (map_tab[i]) map_tab[i] = 0;
      for (int i = cp_defs; i < defs_n && i < cmca_pkg::DEF_DEPTH; i++)
        for (int j = 0; j < 2; j++)
          if (in_span(defs[i][j], base, count)) map_tab[defs[i][j] - base] = 1;
      for (int i = base; i < count; i++)
        if (node_rf[i]) map_tab[i - base] = 1;
      for (int i = count; i > base; i--) begin
        n = i - 1;
        if (map_tab[n - base] != 0)
          for (int j = 0; j < cmca_pkg::CHILDREN; j++)
            if (in_span(node_ch[n][j], base, count)) map_tab[node_ch[n][j] - base] = 1;
      end
      nxt = base;
      for (int i = base; i < count; i++) begin
        if (map_tab[i - base] == 0) continue;
        for (int j = 0; j < cmca_pkg::CHILDREN; j++)
          tmp[j] = cmca_pkg::TERM_W'(remap(node_ch[i][j], base, count));
        rfv = node_rf[i];
        map_tab[i - base] = nxt;
        for (int j = 0; j < cmca_pkg::CHILDREN; j++) node_ch[nxt][j] = tmp[j];
        node_rf[nxt] = rfv;
        nxt++;
      end
      for (int i = cp_defs; i < defs_n && i < cmca_pkg::DEF_DEPTH; i++)
        for (int j = 0; j < 2; j++)
          defs[i][j] = cmca_pkg::TERM_W'(remap(defs[i][j], base, count));
      nodes = nxt;
      cp_nodes = 0;
      rel_ok = 1;
      rel_start = base;
      rel_len = count - base;
    endfunction

    // Applies one accepted request to the shadow state and queues its response.
    function void note_transfer(arena_req_t q);
      arena_rsp_t r;
      int unsigned idx, off;
      r.status = cmca_pkg::ST_DONE;
      foreach (r.ch[k]) r.ch[k] = '0;
      r.defref = 0; r.dvalue = '0; r.dtype = '0; r.term = '0;
      idx = q.index;
      case (q.op)
        cmca_pkg::OP_APPEND_NODE: begin
          if (nodes >= cmca_pkg::NODE_DEPTH) r.status = cmca_pkg::ST_FULL;
          else begin
            foreach (q.ch[k]) node_ch[nodes][k] = q.ch[k];
            node_rf[nodes] = q.defref;
            r.term = cmca_pkg::TERM_W'(nodes);
            nodes++;
            if (nodes > node_hi) node_hi = nodes;
          end
        end
        cmca_pkg::OP_APPEND_DEF: begin
          if (defs_n >= cmca_pkg::DEF_DEPTH) r.status = cmca_pkg::ST_FULL;
          else begin
            defs[defs_n][0] = q.dvalue;
            defs[defs_n][1] = q.dtype;
            defs_n++;
            if (defs_n > def_hi) def_hi = defs_n;
          end
        end
        cmca_pkg::OP_CHECKPOINT: begin
          rel_ok = 0; rel_len = 0; cp_nodes = nodes; cp_defs = defs_n;
        end
        cmca_pkg::OP_ROLLBACK: begin
          if (cp_nodes == 0) r.status = cmca_pkg::ST_IGNORED;
          else begin
            nodes = cp_nodes; defs_n = cp_defs; cp_nodes = 0; err_flag = 0;
          end
        end
        cmca_pkg::OP_COMMIT: begin
          if (cp_nodes == 0) r.status = cmca_pkg::ST_IGNORED;
          else if (err_flag) r.status = cmca_pkg::ST_ERROR;
          else compact();
        end
        cmca_pkg::OP_READ_NODE: begin
          foreach (r.ch[k]) r.ch[k] = node_ch[idx][k];
          r.defref = node_rf[idx];
        end
        cmca_pkg::OP_READ_DEF: begin
          if (idx < cmca_pkg::DEF_DEPTH) begin
            r.dvalue = defs[idx][0];
            r.dtype = defs[idx][1];
          end
        end
        cmca_pkg::OP_RELOCATE: begin
          if (idx == 0) r.term = '0;
          else if (!rel_ok || idx < rel_start) r.term = cmca_pkg::TERM_W'(idx);
          else begin
            off = idx - rel_start;
            r.term = (off < rel_len && off < cmca_pkg::NODE_DEPTH) ?
                     cmca_pkg::TERM_W'(map_tab[off]) : '0;
          end
        end
        cmca_pkg::OP_RAISE_ERROR: err_flag = 1;
        default: ;
      endcase
      r.ncount = cmca_pkg::NCNT_W'(nodes);
      r.dcount = cmca_pkg::DCNT_W'(defs_n);
      pending.push_back(r);
    endfunction

    function void cmp(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compares one response from the block with the oldest expectation.
    function void check(arena_rsp_t a);
      arena_rsp_t e;
      if (pending.size() == 0) begin
        $error("response arrived with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("status", e.status, a.status);
      cmp("out_child_a", e.ch[0], a.ch[0]);
      cmp("out_child_b", e.ch[1], a.ch[1]);
      cmp("out_child_c", e.ch[2], a.ch[2]);
      cmp("out_child_d", e.ch[3], a.ch[3]);
      cmp("out_is_defref", e.defref, a.defref);
      cmp("out_def_value", e.dvalue, a.dvalue);
      cmp("out_def_type", e.dtype, a.dtype);
      cmp("out_term", e.term, a.term);
      cmp("node_count", e.ncount, a.ncount);
      cmp("def_count", e.dcount, a.dcount);
    endfunction
  endclass

  logic                        clk_i = 0;
  logic                        rst_ni = 0;
  logic                        in_valid_i = 0;
  logic                        in_ready_o;
  logic [3:0]                  opcode_i = '0;
  logic [cmca_pkg::TERM_W-1:0] index_i = '0, child_a_i = '0, child_b_i = '0, child_c_i = '0;
  logic [cmca_pkg::TERM_W-1:0] child_d_i = '0, def_value_i = '0, def_type_i = '0;
  logic                        is_defref_i = 0;
  logic                        out_valid_o;
  logic                        out_ready_i = 0;
  logic [1:0]                  status_o;
  logic [cmca_pkg::TERM_W-1:0] out_child_a_o, out_child_b_o, out_child_c_o, out_child_d_o;
  logic                        out_is_defref_o;
  logic [cmca_pkg::TERM_W-1:0] out_def_value_o, out_def_type_o, out_term_o;
  logic [cmca_pkg::NCNT_W-1:0] node_count_o;
  logic [cmca_pkg::DCNT_W-1:0] def_count_o;

  arena_scoreboard sb = new();
  bit              no_stall = 0;

  checkpoint_mark_compact_arena dut (.*);

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Run limit.
  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Output side: random back-pressure, then check each response transfer.
  initial begin
    arena_rsp_t a;
    int g;
    @(posedge rst_ni);
    forever begin
      g = no_stall ? 0 : $urandom_range(0, 5);
      if (g > 0) begin
        out_ready_i <= 0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
      a.status = status_o;
      a.ch[0] = out_child_a_o; a.ch[1] = out_child_b_o;
      a.ch[2] = out_child_c_o; a.ch[3] = out_child_d_o;
      a.defref = out_is_defref_o; a.dvalue = out_def_value_o; a.dtype = out_def_type_o;
      a.term = out_term_o; a.ncount = node_count_o; a.dcount = def_count_o;
      sb.check(a);
    end
  end

  // Input side: optional idle gap, then hold the request until its transfer.
  task automatic send(arena_req_t q);
    int g;
    g = no_stall ? 0 : $urandom_range(0, 5);
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    opcode_i <= q.op; index_i <= q.index;
    child_a_i <= q.ch[0]; child_b_i <= q.ch[1]; child_c_i <= q.ch[2]; child_d_i <= q.ch[3];
    is_defref_i <= q.defref; def_value_i <= q.dvalue; def_type_i <= q.dtype;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(q);
  endtask

  // Drops valid and waits until every outstanding response has come back.
  task automatic drain();
    in_valid_i <= 0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  // A request with every field random; callers override what matters.
  function automatic arena_req_t noise(logic [3:0] op);
    arena_req_t q;
    q.op = op; q.index = cmca_pkg::TERM_W'($urandom);
    foreach (q.ch[k]) q.ch[k] = cmca_pkg::TERM_W'($urandom);
    q.defref = 1'($urandom);
    q.dvalue = cmca_pkg::TERM_W'($urandom);
    q.dtype = cmca_pkg::TERM_W'($urandom);
    if (op == cmca_pkg::OP_READ_NODE)
      q.index = cmca_pkg::TERM_W'($urandom_range(1, sb.node_hi - 1));
    if (op == cmca_pkg::OP_READ_DEF)
      q.index = (sb.def_hi == 0 || $urandom_range(0, 3) == 0) ?
                cmca_pkg::TERM_W'($urandom_range(cmca_pkg::DEF_DEPTH, 4095)) :
                cmca_pkg::TERM_W'($urandom_range(0, sb.def_hi - 1));
    return q;
  endfunction

  // Term mostly inside or just behind the open region, sometimes null or dangling.
  function automatic logic [cmca_pkg::TERM_W-1:0] pick_term();
    int unsigned lo;
    lo = (sb.cp_nodes > 2) ? sb.cp_nodes - 2 : 1;
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return cmca_pkg::TERM_W'($urandom);
      4:       return cmca_pkg::TERM_W'(sb.nodes + $urandom_range(0, 2));
      default: return (sb.nodes > lo) ?
                      cmca_pkg::TERM_W'($urandom_range(lo, sb.nodes - 1)) : '0;
    endcase
  endfunction

  function automatic arena_req_t node_req(logic defref, logic [cmca_pkg::TERM_W-1:0] a,
                                         logic [cmca_pkg::TERM_W-1:0] b,
                                         logic [cmca_pkg::TERM_W-1:0] c,
                                         logic [cmca_pkg::TERM_W-1:0] d);
    arena_req_t q;
    q = noise(cmca_pkg::OP_APPEND_NODE);
    q.defref = defref; q.ch[0] = a; q.ch[1] = b; q.ch[2] = c; q.ch[3] = d;
    return q;
  endfunction

  function automatic arena_req_t def_req(logic [cmca_pkg::TERM_W-1:0] v,
                                        logic [cmca_pkg::TERM_W-1:0] t);
    arena_req_t q;
    q = noise(cmca_pkg::OP_APPEND_DEF);
    q.dvalue = v; q.dtype = t;
    return q;
  endfunction

  function automatic arena_req_t idx_req(logic [3:0] op, logic [cmca_pkg::TERM_W-1:0] idx);
    arena_req_t q;
    q = noise(op);
    q.index = idx;
    return q;
  endfunction

  // Well-formed transaction: checkpoint, appends, optional error, then commit or rollback.
  task automatic transaction();
    int n;
    arena_req_t q;
    send(noise(cmca_pkg::OP_CHECKPOINT));
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1:    send(def_req(pick_term(), pick_term()));
        2:       send(noise(cmca_pkg::OP_READ_NODE));
        default: send(node_req($urandom_range(0, 9) < 3, pick_term(), pick_term(),
                               pick_term(), pick_term()));
      endcase
    end
    if ($urandom_range(0, 6) == 0) send(noise(cmca_pkg::OP_RAISE_ERROR));
    if ($urandom_range(0, 9) < 7) send(noise(cmca_pkg::OP_COMMIT));
    else send(noise(cmca_pkg::OP_ROLLBACK));
    if (sb.err_flag && $urandom_range(0, 1)) send(noise(cmca_pkg::OP_ROLLBACK));
    repeat ($urandom_range(1, 4)) begin
      q = idx_req(cmca_pkg::OP_RELOCATE,
                  cmca_pkg::TERM_W'(sb.rel_start + $urandom_range(0, sb.rel_len + 2)));
      send(q);
    end
    send(noise(cmca_pkg::OP_READ_DEF));
  endtask

  initial begin
    arena_req_t q;
    int items;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: no checkpoint, error pending, dangling and forward children, all reads.
    send(node_req(1, '0, '0, '0, '0));
    send(node_req(0, 12'hFFF, 12'd1, '0, '0));
    send(noise(cmca_pkg::OP_ROLLBACK));
    send(noise(cmca_pkg::OP_COMMIT));
    send(idx_req(cmca_pkg::OP_RELOCATE, 12'd2));
    send(noise(cmca_pkg::OP_CHECKPOINT));
    send(node_req(0, 12'd1, 12'd2, '0, '0));
    send(node_req(1, 12'd3, 12'd5, 12'd4, 12'hFFF));
    send(node_req(0, 12'd3, '0, '0, '0));
    send(def_req(12'd5, 12'hFFF));
    send(noise(cmca_pkg::OP_RAISE_ERROR));
    send(noise(cmca_pkg::OP_COMMIT));
    send(node_req(1, '0, '0, '0, '0));
    send(noise(cmca_pkg::OP_ROLLBACK));
    send(noise(cmca_pkg::OP_CHECKPOINT));
    send(node_req(0, 12'd1, '0, '0, '0));
    send(node_req(1, 12'd3, 12'd4, 12'd2, '0));
    send(def_req(12'd3, 12'd2));
    send(noise(cmca_pkg::OP_COMMIT));
    send(idx_req(cmca_pkg::OP_RELOCATE, 12'd0));
    send(idx_req(cmca_pkg::OP_RELOCATE, 12'd1));
    send(idx_req(cmca_pkg::OP_RELOCATE, 12'd4));
    send(idx_req(cmca_pkg::OP_RELOCATE, 12'hFFF));
    send(idx_req(cmca_pkg::OP_READ_NODE, 12'd3));
    send(idx_req(cmca_pkg::OP_READ_DEF, 12'd300));
    send(idx_req(cmca_pkg::OP_READ_DEF, 12'd0));
    send(noise(OP_SPARE_LO));
    send(noise(OP_SPARE_HI));

    // Hold off until everything outstanding has come back.
    drain();

    // Random: mostly well-formed transactions, the rest single random requests.
    items = 0;
    while (items < 160) begin
      if (items % 80 < 15) no_stall = 1;
      else no_stall = 0;
      if ($urandom_range(0, 9) < 6) begin
        transaction();
        items += 10;
      end else begin
        q = noise(4'($urandom_range(0, OP_SPARE_HI)));
        if (q.op == cmca_pkg::OP_READ_NODE && sb.node_hi < 2) q.op = cmca_pkg::OP_RELOCATE;
        send(q);
        items++;
      end
      if ($urandom_range(0, 30) == 0) drain();
    end

    // Fill the definition store and push one more into it.
    no_stall = 0;
    while (sb.defs_n < cmca_pkg::DEF_DEPTH)
      send(def_req(cmca_pkg::TERM_W'($urandom), cmca_pkg::TERM_W'($urandom)));
    send(def_req(cmca_pkg::TERM_W'($urandom), cmca_pkg::TERM_W'($urandom)));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[checkpoint_mark_compact_arena.f]
rtl/core/cmca_pkg.sv
rtl/core/cmca_ram.sv
rtl/core/checkpoint_mark_compact_arena.sv
rtl/core/cmca_checker.sv
bench/tb_checkpoint_mark_compact_arena.sv
